/* src/vnf_pkg.sv */
package vnf_pkg;

    // Hash multipliers of the lattice avalanche mix.
    localparam logic [31:0] HASH_K_IDX    = 32'h9E3779B1;
    localparam logic [31:0] HASH_K_SEED   = 32'h85EBCA6B;
    localparam logic [31:0] HASH_K_MIX1   = 32'h7FEB352D;
    localparam logic [31:0] HASH_K_MIX2   = 32'h846CA68B;
    // Seed increment from one octave to the next.
    localparam logic [31:0] OCT_SEED_STEP = 32'h1F123BB5;

    // Width of a lattice value and of the blended octave noise (Q0.24).
    localparam int NOISE_W = 24;
    // Width of the fraction and of the smoothstep weight (Q0.16).
    localparam int T_W = 16;

    // Register stages inside one octave lane.
    localparam int LANE_STAGES = 8;

    // Configuration register indexes.
    typedef enum logic {
        REG_BASE_SEED = 1'b0,
        REG_OCTAVES   = 1'b1
    } reg_idx_t;

    // Levels of the registered adder tree over the octave lanes.
    function automatic int vnf_tree_levels(input int lanes);
        int lv;
        lv = $clog2(lanes);
        return (lv < 1) ? 1 : lv;
    endfunction

endpackage

/* src/vnf_pipe_ctrl.sv */
module vnf_pipe_ctrl #(
    parameter int STAGES = 14
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [STAGES-1:0] en
);

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;

    // A stage may load when it or any stage after it is empty, or the
    // output beat leaves in this cycle.
    for (genvar k = 0; k < STAGES; k++) begin : g_rdy
        assign en[k] = m_tready | ~(&vld_reg[STAGES-1:k]);
    end

    // Valid bits follow the data one stage per enabled cycle.
    always_comb begin
        vld_next = vld_reg;
        for (int k = 0; k < STAGES; k++) begin
            if (en[k]) begin
                vld_next[k] = (k == 0) ? s_tvalid : vld_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[STAGES-1];

endmodule

/* src/vnf_octave_lane.sv */
module vnf_octave_lane
    import vnf_pkg::*;
#(
    parameter int LANE      = 0,
    parameter int FRAC_BITS = 16
) (
    input  logic                   aclk,
    input  logic [LANE_STAGES-1:0] en,
    input  logic [31:0]            x_position,
    input  logic [31:0]            base_seed,
    output logic [NOISE_W-1:0]     noise
);

    localparam int POS_W = FRAC_BITS + 32;
    // 37.31 in the position format, rounded to nearest.
    localparam logic [63:0] OFS_FULL      = ((64'd3731 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [63:0] LANE_OFS_FULL = OFS_FULL * 64'(LANE);
    localparam logic [POS_W-1:0] LANE_OFS = LANE_OFS_FULL[POS_W-1:0];
    localparam logic [63:0] LANE_STEP_FULL = 64'(LANE) * 64'(OCT_SEED_STEP);
    localparam logic [31:0] LANE_STEP     = LANE_STEP_FULL[31:0];
    localparam logic [17:0] SMOOTH_THREE  = 18'd196608;

    // Seed term of the hash; it follows the seed register, which the user must
    // change only while no beat is in flight; the block does not enforce this.
    logic [31:0] seed_sum;
    logic [31:0] seedk_reg;

    assign seed_sum = base_seed + LANE_STEP;

    always_ff @(posedge aclk) begin
        seedk_reg <= seed_sum * HASH_K_SEED;
    end

    // Stage 1: octave position, lattice index and fraction.
    logic [POS_W-1:0] x_ext;
    logic [POS_W-1:0] pos;
    logic [T_W-1:0]   t_next;
    logic [31:0]      idx_reg;
    logic [T_W-1:0]   t_s1_reg;

    assign x_ext = {{FRAC_BITS{x_position[31]}}, x_position};
    assign pos   = (x_ext << LANE) + LANE_OFS;

    if (FRAC_BITS >= T_W) begin : g_t_trunc
        assign t_next = pos[FRAC_BITS-1 -: T_W];
    end else begin : g_t_widen
        assign t_next = {pos[FRAC_BITS-1:0], {(T_W-FRAC_BITS){1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            idx_reg  <= pos[POS_W-1:FRAC_BITS];
            t_s1_reg <= t_next;
        end
    end

    // Stage 2: index products for both lattice points, fraction squared.
    logic [31:0]    ma0_reg;
    logic [31:0]    mb0_reg;
    logic [31:0]    t2_reg;
    logic [T_W-1:0] t_s2_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            ma0_reg  <= idx_reg * HASH_K_IDX;
            mb0_reg  <= (idx_reg + 32'd1) * HASH_K_IDX;
            t2_reg   <= 32'(t_s1_reg) * 32'(t_s1_reg);
            t_s2_reg <= t_s1_reg;
        end
    end

    // Stage 3: seed mix-in and the smoothstep weight u = t*t*(3 - 2t).
    logic [17:0]    s_next;
    logic [49:0]    su_next;
    logic [31:0]    ha_reg;
    logic [31:0]    hb_reg;
    logic [T_W-1:0] u_s3_reg;

    assign s_next  = SMOOTH_THREE - {1'b0, t_s2_reg, 1'b0};
    assign su_next = {18'd0, t2_reg} * {32'd0, s_next};

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            ha_reg   <= ma0_reg + seedk_reg;
            hb_reg   <= mb0_reg + seedk_reg;
            u_s3_reg <= su_next[47:32];
        end
    end

    // Stage 4: first avalanche round.
    logic [31:0]    ma1_reg;
    logic [31:0]    mb1_reg;
    logic [T_W-1:0] u_s4_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            ma1_reg  <= (ha_reg ^ (ha_reg >> 16)) * HASH_K_MIX1;
            mb1_reg  <= (hb_reg ^ (hb_reg >> 16)) * HASH_K_MIX1;
            u_s4_reg <= u_s3_reg;
        end
    end

    // Stage 5: second avalanche round.
    logic [31:0]    ma2_reg;
    logic [31:0]    mb2_reg;
    logic [T_W-1:0] u_s5_reg;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            ma2_reg  <= (ma1_reg ^ (ma1_reg >> 15)) * HASH_K_MIX2;
            mb2_reg  <= (mb1_reg ^ (mb1_reg >> 15)) * HASH_K_MIX2;
            u_s5_reg <= u_s4_reg;
        end
    end

    // Stage 6: final fold to 24 bits and the magnitude of b - a.
    logic [31:0]        za_next;
    logic [31:0]        zb_next;
    logic [NOISE_W-1:0] a_next;
    logic [NOISE_W-1:0] b_next;
    logic [NOISE_W-1:0] a_s6_reg;
    logic [NOISE_W-1:0] diff_reg;
    logic               ge_s6_reg;
    logic [T_W-1:0]     u_s6_reg;

    assign za_next = ma2_reg ^ (ma2_reg >> 16);
    assign zb_next = mb2_reg ^ (mb2_reg >> 16);
    assign a_next  = za_next[31:8];
    assign b_next  = zb_next[31:8];

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            a_s6_reg  <= a_next;
            ge_s6_reg <= (b_next >= a_next);
            diff_reg  <= (b_next >= a_next) ? (b_next - a_next) : (a_next - b_next);
            u_s6_reg  <= u_s5_reg;
        end
    end

    // Stage 7: scaled step, truncated toward zero.
    logic [NOISE_W+T_W-1:0] dp_next;
    logic [NOISE_W-1:0]     step_reg;
    logic [NOISE_W-1:0]     a_s7_reg;
    logic                   ge_s7_reg;

    assign dp_next = {{T_W{1'b0}}, diff_reg} * {{NOISE_W{1'b0}}, u_s6_reg};

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            step_reg  <= dp_next[NOISE_W+T_W-1:T_W];
            a_s7_reg  <= a_s6_reg;
            ge_s7_reg <= ge_s6_reg;
        end
    end

    // Stage 8: blended octave value.
    logic [NOISE_W-1:0] noise_reg;

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            noise_reg <= ge_s7_reg ? (a_s7_reg + step_reg) : (a_s7_reg - step_reg);
        end
    end

    assign noise = noise_reg;

endmodule

/* src/vnf_norm.sv */
module vnf_norm
    import vnf_pkg::*;
#(
    parameter int MAX_OCTAVES = 12,
    parameter int CNT_W       = $clog2(MAX_OCTAVES + 1),
    parameter int NORM_STAGES = vnf_tree_levels(MAX_OCTAVES) + 2
) (
    input  logic                                  aclk,
    input  logic [NORM_STAGES-1:0]                en,
    input  logic [CNT_W-1:0]                      octave_count,
    input  logic [MAX_OCTAVES-1:0][NOISE_W-1:0]   noise_lanes,
    output logic [15:0]                           noise_value
);

    localparam int TREE_LV = vnf_tree_levels(MAX_OCTAVES);
    localparam int LEAVES  = 1 << TREE_LV;
    localparam int SUM_W   = NOISE_W + MAX_OCTAVES;
    localparam int REC_W   = MAX_OCTAVES + 26;
    localparam int RSHIFT  = 32 + 2 * MAX_OCTAVES;
    localparam int HALF_W  = (SUM_W + 1) / 2;
    localparam int HIGH_W  = SUM_W - HALF_W;
    localparam int PROD_W  = SUM_W + REC_W;
    localparam int Q_W     = PROD_W - RSHIFT;

    // Heap-ordered adder tree: inner nodes 1..LEAVES-1 are registers, the
    // leaves are the weighted and masked octave values.
    logic [SUM_W-1:0] node [1:2*LEAVES-1];
    logic [SUM_W-1:0] tree_reg [1:LEAVES-1];

    // Octave i carries weight 2^(MAX_OCTAVES-1-i); unused octaves add zero.
    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < MAX_OCTAVES) begin : g_used
            assign node[LEAVES+i] = (octave_count > CNT_W'(i)) ?
                (SUM_W'(noise_lanes[i]) << (MAX_OCTAVES - 1 - i)) : '0;
        end else begin : g_pad
            assign node[LEAVES+i] = '0;
        end
    end

    for (genvar k = 1; k < LEAVES; k++) begin : g_node
        localparam int DEPTH = $clog2(k + 1) - 1;
        localparam int STG   = TREE_LV - 1 - DEPTH;

        assign node[k] = tree_reg[k];

        always_ff @(posedge aclk) begin
            if (en[STG]) begin
                tree_reg[k] <= node[2*k] + node[2*k+1];
            end
        end
    end

    // Reciprocal of 256 * (2^c - 1) * 2^(MAX_OCTAVES - c), rounded up, scaled
    // by 2^RSHIFT: exact floor quotient for every sum the tree can hold.
    logic [REC_W-1:0] recip_tab [0:MAX_OCTAVES];

    for (genvar c = 0; c <= MAX_OCTAVES; c++) begin : g_recip
        if (c == 0) begin : g_none
            assign recip_tab[c] = '0;
        end else begin : g_cnt
            localparam logic [127:0] DEN = (128'd1 << (MAX_OCTAVES + 8)) -
                                           (128'd1 << (MAX_OCTAVES + 8 - c));
            localparam logic [127:0] NUM = 128'd1 << RSHIFT;
            localparam logic [127:0] RC  = (NUM + DEN - 128'd1) / DEN;
            assign recip_tab[c] = RC[REC_W-1:0];
        end
    end

    // Reciprocal multiply, split into two partial products.
    logic [REC_W-1:0]        recip;
    logic [HALF_W+REC_W-1:0] plo_reg;
    logic [HIGH_W+REC_W-1:0] phi_reg;

    assign recip = recip_tab[octave_count];

    always_ff @(posedge aclk) begin
        if (en[TREE_LV]) begin
            plo_reg <= {{REC_W{1'b0}}, tree_reg[1][HALF_W-1:0]} *
                       {{HALF_W{1'b0}}, recip};
            phi_reg <= {{REC_W{1'b0}}, tree_reg[1][SUM_W-1:HALF_W]} *
                       {{HIGH_W{1'b0}}, recip};
        end
    end

    // Recombine, drop the reciprocal scale and clamp to Q0.16.
    logic [PROD_W-1:0] prod_next;
    logic [Q_W-1:0]    q_next;
    logic [15:0]       noise_value_reg;

    assign prod_next = (PROD_W'(phi_reg) << HALF_W) + PROD_W'(plo_reg);
    assign q_next    = prod_next[PROD_W-1:RSHIFT];

    always_ff @(posedge aclk) begin
        if (en[TREE_LV+1]) begin
            noise_value_reg <= (q_next > Q_W'(16'hFFFF)) ? 16'hFFFF : q_next[15:0];
        end
    end

    assign noise_value = noise_value_reg;

endmodule

/* src/value_noise_fbm_1d_unit.sv */
// One-dimensional fractal value noise. Each s_ beat carries a signed Q16.16
// position; each m_ beat returns its fBm value in unsigned Q0.16, in order.
// The block takes one beat per clock while the result side does not stall
// it, and holds any number of beats in flight up to its depth. The pipeline
// runs through the per-octave lane (index hash, two avalanche multiply
// rounds, fold, blend), the registered adder tree over the octave lanes,
// and the split reciprocal multiply that divides by the weight total. All
// octaves up to MAX_OCTAVES are computed side by side, so the octave count
// changes the value but not the timing. Write base_seed
// (offset 0) and octave_count (offset 4, saturates to 1..MAX_OCTAVES) only
// while no beat is in flight; the new value applies to every beat accepted
// after the write.
module value_noise_fbm_1d_unit
    import vnf_pkg::*;
#(
    parameter int MAX_OCTAVES = 12,
    parameter int FRAC_BITS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input beat: [31:0] x_position
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // Result beat: [15:0] noise_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W       = $clog2(MAX_OCTAVES + 1);
    localparam int NORM_STAGES = vnf_tree_levels(MAX_OCTAVES) + 2;
    localparam int STAGES      = LANE_STAGES + NORM_STAGES;
    localparam int RESET_CNT   = (MAX_OCTAVES < 4) ? MAX_OCTAVES : 4;

    // Configuration registers.
    logic [31:0]      base_seed_reg;
    logic [CNT_W-1:0] octave_count_reg;
    logic [CNT_W-1:0] octave_count_next;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    // Octave count writes saturate to 1..MAX_OCTAVES.
    always_comb begin
        if (pwdata == 32'd0) begin
            octave_count_next = CNT_W'(1);
        end else if (pwdata > 32'(MAX_OCTAVES)) begin
            octave_count_next = CNT_W'(MAX_OCTAVES);
        end else begin
            octave_count_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_seed_reg    <= '0;
            octave_count_reg <= CNT_W'(RESET_CNT);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_BASE_SEED: base_seed_reg    <= pwdata;
                REG_OCTAVES:   octave_count_reg <= octave_count_next;
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (cfg_idx)
            REG_BASE_SEED: prdata = base_seed_reg;
            REG_OCTAVES:   prdata = 32'(octave_count_reg);
            default:       prdata = '0;
        endcase
    end

    // Stage enables and valid bits for the whole pipeline.
    logic [STAGES-1:0] en;

    vnf_pipe_ctrl #(
        .STAGES(STAGES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .en      (en)
    );

    // One lane per octave.
    logic [MAX_OCTAVES-1:0][NOISE_W-1:0] noise_lanes;

    for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
        vnf_octave_lane #(
            .LANE     (i),
            .FRAC_BITS(FRAC_BITS)
        ) u_lane (
            .aclk      (aclk),
            .en        (en[LANE_STAGES-1:0]),
            .x_position(s_tdata),
            .base_seed (base_seed_reg),
            .noise     (noise_lanes[i])
        );
    end

    // Weighted sum and normalization.
    vnf_norm #(
        .MAX_OCTAVES(MAX_OCTAVES),
        .CNT_W      (CNT_W),
        .NORM_STAGES(NORM_STAGES)
    ) u_norm (
        .aclk        (aclk),
        .en          (en[STAGES-1:LANE_STAGES]),
        .octave_count(octave_count_reg),
        .noise_lanes (noise_lanes),
        .noise_value (m_tdata)
    );

endmodule

/* src/vnf_checker.sv */
module vnf_checker
    import vnf_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // Byte address of the octave count register.
    localparam logic [2:0] OCTAVES_ADDR = {REG_OCTAVES, 2'b00};

    // Beats accepted but not yet delivered.
    logic [7:0] pend_reg;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + 8'(in_beat) - 8'(out_beat);
        end
    end

    // A stalled result beat holds its data.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // With the output free, the pipeline can always take a beat.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while output side is free");

    // Every result beat belongs to an accepted input beat.
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 8'd0)
        else $error("result beat without pending input beat");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // An octave count write of zero reads back as one.
    a_cnt_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready && paddr == OCTAVES_ADDR && pwdata == 32'd0
        |=> (paddr != OCTAVES_ADDR || prdata == 32'd1))
        else $error("octave count write of zero not saturated");

endmodule

bind value_noise_fbm_1d_unit vnf_checker u_vnf_checker (.*);

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import vnf_pkg::*;

    localparam int MAX_OCT = 12;
    localparam int FRAC = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_BEATS = 200;
    localparam int TAIL_CYCLES = 40;
    // Octave offset 37.31 in Q16.16, rounded to nearest.
    localparam logic [63:0] OCT_SHIFT = ((64'd3731 << FRAC) + 64'd50) / 64'd100;
    localparam logic [2:0] SEED_ADDR = {REG_BASE_SEED, 2'b00};
    localparam logic [2:0] OCTAVES_ADDR = {REG_OCTAVES, 2'b00};

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // One directed probe: optional register load, then one position beat.
    typedef struct packed {
        logic        load;
        logic [31:0] seed;
        logic [31:0] octaves;
        logic [31:0] x;
    } probe_t;

    // Integer and fraction extremes, the saturating octave writes, and the
    // seed extremes. The hashes leave no value to read off by hand, so every
    // probe is checked against the predictor.
    localparam probe_t PROBE_TABLE [18] = '{
        '{1'b0, 32'h0000_0000, 32'd4,         32'h0000_0000},
        '{1'b0, 32'h0000_0000, 32'd4,         32'h7FFF_FFFF},
        '{1'b0, 32'h0000_0000, 32'd4,         32'h8000_0000},
        '{1'b0, 32'h0000_0000, 32'd4,         32'hFFFF_FFFF},
        '{1'b1, 32'hFFFF_FFFF, 32'd0,         32'h0000_FFFF},
        '{1'b0, 32'hFFFF_FFFF, 32'd0,         32'h0000_8000},
        '{1'b0, 32'hFFFF_FFFF, 32'd0,         32'h0001_0000},
        '{1'b1, 32'h0000_0000, 32'd1,         32'hFFFF_0000},
        '{1'b1, 32'h1234_5678, 32'd12,        32'h7FFF_FFFF},
        '{1'b0, 32'h1234_5678, 32'd12,        32'h8000_0000},
        '{1'b0, 32'h1234_5678, 32'd12,        32'h0000_FFFF},
        '{1'b1, 32'hFFFF_FFFF, 32'd13,        32'hFFFF_FFFF},
        '{1'b0, 32'hFFFF_FFFF, 32'd13,        32'h0000_0001},
        '{1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555},
        '{1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA},
        '{1'b1, 32'h0000_0001, 32'd2,         32'h0001_8000},
        '{1'b1, 32'h9E37_79B1, 32'd15,        32'h0000_7FFF},
        '{1'b1, 32'h0000_0000, 32'd4,         32'h0000_0000}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the configuration registers.
    logic [31:0] seed_cfg = '0;
    logic [3:0]  octave_cfg = 4'd4;

    logic [15:0] noise_q [$];
    logic [15:0] noise_head;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    value_noise_fbm_1d_unit #(
        .MAX_OCTAVES(MAX_OCT),
        .FRAC_BITS(FRAC)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Avalanche hash of one lattice node, top 24 bits as Q0.24.
    function automatic logic [23:0] lattice_value(input logic [31:0] node,
                                                  input logic [31:0] seed);
        logic [31:0] h;
        h = node * HASH_K_IDX + seed * HASH_K_SEED;
        h = h ^ (h >> 16);
        h = h * HASH_K_MIX1;
        h = h ^ (h >> 15);
        h = h * HASH_K_MIX2;
        h = h ^ (h >> 16);
        return h[31:8];
    endfunction

    // One octave: smoothstep blend of the two neighboring lattice values.
    function automatic logic [23:0] octave_value(input logic [63:0] pos,
                                                 input logic [31:0] seed);
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] d;
        logic [63:0] blend;
        logic [23:0] a;
        logic [23:0] b;
        t = {48'd0, pos[FRAC-1:0]};
        u = (t * t * (64'd196608 - 64'd2 * t)) >> 32;
        a = lattice_value(pos[FRAC+31:FRAC], seed);
        b = lattice_value(pos[FRAC+31:FRAC] + 32'd1, seed);
        d = (b >= a) ? 64'(b - a) : 64'(a - b);
        blend = (d * u) >> 16;
        return (b >= a) ? a + blend[23:0] : a - blend[23:0];
    endfunction

    // Weighted octave sum, divided by the weight total, in Q0.16.
    function automatic logic [15:0] fbm_noise(input logic [31:0] x,
                                              input logic [31:0] seed,
                                              input int octaves);
        logic [63:0] xs;
        logic [63:0] pos;
        logic [63:0] total;
        logic [63:0] quo;
        logic [31:0] oct_seed;
        int          i;
        xs = {{32{x[31]}}, x};
        total = '0;
        for (i = 0; i < octaves; i++) begin
            pos = (xs << i) + 64'(i) * OCT_SHIFT;
            oct_seed = seed + 32'(i) * OCT_SEED_STEP;
            total = total + (64'(octave_value(pos, oct_seed)) << (octaves - 1 - i));
        end
        quo = (total / ((64'd1 << octaves) - 64'd1)) >> 8;
        return (quo > 64'd65535) ? 16'hFFFF : quo[15:0];
    endfunction

    // Random position: full range, near zero, near the integer extremes,
    // or on lattice and fraction edges.
    function automatic logic [31:0] random_position();
        case ($urandom_range(5))
            0, 1: return $urandom;
            2: return 32'($urandom_range(20 << 16)) - 32'(10 << 16);
            3: return {($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000, 16'($urandom)};
            4: return {16'($urandom), 16'h0000};
            default: return {16'($urandom), ($urandom_range(1) != 0) ? 16'hFFFF : 16'h8000};
        endcase
    endfunction

    // Result channel: random stalls, and field check against the oldest beat.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (noise_q.size() == 0) begin
                $error("noise_value: expected none, got %h", m_tdata);
                mismatches++;
            end else begin
                noise_head = noise_q.pop_front();
                if (m_tdata !== noise_head) begin
                    $error("noise_value: expected %h, got %h", noise_head, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Send one position beat, after a random gap, and queue its prediction.
    task automatic send_position(input logic [31:0] x);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= x;
        do @(posedge aclk); while (!s_tready);
        noise_q.push_back(fbm_noise(x, seed_cfg, octave_cfg));
    endtask

    // Stop sending and wait until every expected result has come.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (noise_q.size() != 0);
    endtask

    // Write one register, track it, and read it back.
    task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= (idx == REG_BASE_SEED) ? SEED_ADDR : OCTAVES_ADDR;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_BASE_SEED) begin
            seed_cfg = value;
        end else begin
            octave_cfg = (value == 0) ? 4'd1 : (value > MAX_OCT) ? 4'(MAX_OCT) : value[3:0];
        end
        // Readback in the next transfer.
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_BASE_SEED && prdata !== seed_cfg) begin
            $error("base_seed: expected %h, got %h", seed_cfg, prdata);
            mismatches++;
        end else if (idx == REG_OCTAVES && prdata[3:0] !== octave_cfg) begin
            $error("octave_count: expected %0d, got %0d", octave_cfg, prdata[3:0]);
            mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Load both registers while idle, then leave a few quiet cycles.
    task automatic load_config(input logic [31:0] seed, input logic [31:0] octaves);
        write_register(REG_BASE_SEED, seed);
        write_register(REG_OCTAVES, octaves);
        repeat (3) @(posedge aclk);
    endtask

    initial begin
        idle_mode_t  mode;
        logic [31:0] seed;
        logic [31:0] octaves;
        int          p;
        int          n;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed probes, back to back.
        for (p = 0; p < $size(PROBE_TABLE); p++) begin
            if (PROBE_TABLE[p].load) begin
                drain_results();
                load_config(PROBE_TABLE[p].seed, PROBE_TABLE[p].octaves);
            end
            send_position(PROBE_TABLE[p].x);
        end

        // Random phases over the idling modes and register settings.
        for (p = 0; p < PHASE_COUNT; p++) begin
            mode = idle_mode_t'(p % 4);
            case (mode)
                IDLE_NONE: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                IDLE_SENDER: begin
                    send_idle_pct = 83;
                    recv_stall_pct = 0;
                end
                IDLE_RECEIVER: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 83;
                end
                default: begin
                    send_idle_pct = 27;
                    recv_stall_pct = 27;
                end
            endcase
            seed = (p == 3) ? 32'hFFFF_FFFF : (p == 4) ? 32'h0 : $urandom;
            if (p == 3) begin
                octaves = MAX_OCT;
            end else if (p == 4) begin
                octaves = 1;
            end else if ($urandom_range(3) == 0) begin
                octaves = $urandom;
            end else begin
                octaves = $urandom_range(15);
            end
            drain_results();
            load_config(seed, octaves);
            for (n = 0; n < PHASE_BEATS; n++) begin
                // Hold off mid-phase until the pipeline has emptied.
                if (n == PHASE_BEATS / 2) begin
                    drain_results();
                end
                send_position(random_position());
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
